/* rtl/core/isl_pkg.sv */
package isl_pkg;

   // Field widths of the request and response words
   localparam int OpcodeWidth   = 3;
   localparam int PositionWidth = 5;
   localparam int ValueWidth    = 32;
   localparam int CountWidth    = 5;

   // Operation codes
   typedef enum logic [OpcodeWidth-1:0] {
      OP_APPEND     = 3'd0,
      OP_PREPEND    = 3'd1,
      OP_DROP_LAST  = 3'd2,
      OP_DROP_FIRST = 3'd3,
      OP_READ       = 3'd4,
      OP_WRITE      = 3'd5,
      OP_INSERT     = 3'd6,
      OP_REMOVE_AT  = 3'd7
   } op_type;

   // Command from the controller to the datapath
   typedef struct packed {
      logic                         apply;
      op_type                       opcode;
      logic [PositionWidth-1:0]     position;
      logic signed [ValueWidth-1:0] item_value;
   } cmd_type;

endpackage

/* rtl/core/isl_channels.sv */
interface isl_req_if
   import isl_pkg::*;
   ();
   logic                         valid;
   logic                         ready;
   op_type                       opcode;
   logic [PositionWidth-1:0]     position;
   logic signed [ValueWidth-1:0] item_value;

   modport source (output valid, output opcode, output position, output item_value,
                   input ready);
   modport sink   (input valid, input opcode, input position, input item_value,
                   output ready);
endinterface

interface isl_rsp_if
   import isl_pkg::*;
   ();
   logic                         valid;
   logic                         ready;
   logic                         ok;
   logic signed [ValueWidth-1:0] read_value;
   logic [CountWidth-1:0]        count;

   modport source (output valid, output ok, output read_value, output count,
                   input ready);
   modport sink   (input valid, input ok, input read_value, input count,
                   output ready);
endinterface

/* rtl/core/indexed_sequence_list_top.sv */
// Bounded ordered list of up to CAPACITY signed 32-bit entries with append,
// prepend, remove at either end, read, write, insert and remove at an index.
// Each request word yields one response word with an ok flag, the value read
// (zero unless a read succeeds) and the entry count after the operation,
// reported modulo 32. Rejected operations change nothing. The list holds
// words in a chain of registers that shifts as a whole, so every operation
// completes in the cycle it is accepted: the response appears in the next
// cycle and a new request is taken every cycle while responses are drained.
// A response held by a stalled sink stops new requests until it is taken.
module indexed_sequence_list_top
   import isl_pkg::*;
   #(
   parameter int CAPACITY = 16
   )
   (
   input  logic    clock,
   input  logic    reset,
   isl_req_if.sink   req_ch,
   isl_rsp_if.source rsp_ch
   );

   cmd_type cmd;

   isl_controller u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_ch.valid),
      .req_ready      (req_ch.ready),
      .req_opcode     (req_ch.opcode),
      .req_position   (req_ch.position),
      .req_item_value (req_ch.item_value),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .cmd            (cmd)
   );

   isl_datapath #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .ok         (rsp_ch.ok),
      .read_value (rsp_ch.read_value),
      .count      (rsp_ch.count)
   );

endmodule

/* rtl/core/isl_controller.sv */
module isl_controller
   import isl_pkg::*;
   (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  op_type       req_opcode,
   input  logic [PositionWidth-1:0]     req_position,
   input  logic signed [ValueWidth-1:0] req_item_value,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output cmd_type      cmd
   );

   typedef enum logic [1:0] {
      ST_EMPTY = 2'b01,
      ST_HOLD  = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   // Take a new word when no result waits or the waiting one leaves now
   assign req_ready = (state_ff == ST_EMPTY) || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = (state_ff == ST_HOLD);

   // Drive the datapath command
   assign cmd.apply      = accept;
   assign cmd.opcode     = req_opcode;
   assign cmd.position   = req_position;
   assign cmd.item_value = req_item_value;

   // Advance the result-holding state
   always_comb begin
      unique case (state_ff)
         ST_EMPTY: begin
            state_in = accept ? ST_HOLD : ST_EMPTY;
         end
         ST_HOLD: begin
            if (accept) begin
               state_in = ST_HOLD;
            end else if (rsp_ready) begin
               state_in = ST_EMPTY;
            end else begin
               state_in = ST_HOLD;
            end
         end
         default: begin
            state_in = ST_EMPTY;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_EMPTY;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/core/isl_datapath.sv */
module isl_datapath
   import isl_pkg::*;
   #(
   parameter int CAPACITY = 16
   )
   (
   input  logic                         clock,
   input  logic                         reset,
   input  cmd_type                      cmd,
   output logic                         ok,
   output logic signed [ValueWidth-1:0] read_value,
   output logic [CountWidth-1:0]        count
   );

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);
   localparam int XW = (CW > PositionWidth) ? CW : PositionWidth;

   logic [ValueWidth-1:0] cells_ff [CAPACITY];
   logic [ValueWidth-1:0] cells_in [CAPACITY];
   logic [CW-1:0]         count_ff;
   logic [CW-1:0]         count_in;
   logic                  ok_ff;
   logic [ValueWidth-1:0] read_ff;
   logic [ValueWidth-1:0] read_in;

   logic          ins_en;
   logic          rem_en;
   logic          wr_en;
   logic          rd_en;
   logic [XW-1:0] tpos;
   logic [XW-1:0] count_x;
   logic [XW-1:0] pos_x;
   logic [XW-1:0] count_out_x;
   logic          room;

   assign count_x = XW'(count_ff);
   assign pos_x   = XW'(cmd.position);
   assign room    = count_x < XW'(CAPACITY);

   // Decode the operation into insert, remove, write or read at one slot
   always_comb begin
      ins_en = 1'b0;
      rem_en = 1'b0;
      wr_en  = 1'b0;
      rd_en  = 1'b0;
      tpos   = pos_x;
      unique case (cmd.opcode)
         OP_APPEND: begin
            ins_en = room;
            tpos   = count_x;
         end
         OP_PREPEND: begin
            ins_en = room;
            tpos   = '0;
         end
         OP_DROP_LAST: begin
            rem_en = (count_x != '0);
            tpos   = count_x - XW'(1);
         end
         OP_DROP_FIRST: begin
            rem_en = (count_x != '0);
            tpos   = '0;
         end
         OP_READ: begin
            rd_en = (pos_x < count_x);
         end
         OP_WRITE: begin
            wr_en = (pos_x < count_x);
         end
         OP_INSERT: begin
            ins_en = room && (pos_x <= count_x);
         end
         OP_REMOVE_AT: begin
            rem_en = (pos_x < count_x);
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   // Next value of each cell: shift up on insert, down on remove
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         cells_in[i] = cells_ff[i];
         if (ins_en) begin
            if (XW'(i) == tpos) begin
               cells_in[i] = cmd.item_value;
            end else if ((i > 0) && (XW'(i) > tpos)) begin
               cells_in[i] = cells_ff[(i > 0) ? i - 1 : 0];
            end
         end else if (rem_en) begin
            if ((i < CAPACITY - 1) && (XW'(i) >= tpos)) begin
               cells_in[i] = cells_ff[(i < CAPACITY - 1) ? i + 1 : i];
            end
         end else if (wr_en) begin
            if (XW'(i) == tpos) begin
               cells_in[i] = cmd.item_value;
            end
         end
      end
   end

   // Count and read result
   always_comb begin
      priority if (ins_en) begin
         count_in = count_ff + CW'(1);
      end else if (rem_en) begin
         count_in = count_ff - CW'(1);
      end else begin
         count_in = count_ff;
      end
      read_in = rd_en ? cells_ff[tpos[IW-1:0]] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.apply) begin
         count_ff <= count_in;
      end
   end

   // Hold cells and result word; no reset needed
   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         cells_ff <= cells_in;
         ok_ff    <= ins_en || rem_en || wr_en || rd_en;
         read_ff  <= read_in;
      end
   end

   assign count_out_x = XW'(count_ff);
   assign ok          = ok_ff;
   assign read_value  = read_ff;
   assign count       = count_out_x[CountWidth-1:0];

endmodule

/* rtl/core/isl_checker.sv */
module isl_checker
   import isl_pkg::*;
   #(
   parameter int CAPACITY = 16
   )
   (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_ok,
   input logic signed [ValueWidth-1:0] rsp_read_value,
   input logic [CountWidth-1:0]        rsp_count
   );

   // A waiting response word stays until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // Every accepted request gives a response in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted request without response");

   // No response shows after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A rejected operation reads zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_read_value == '0)
      else $error("rejected operation returned data");

   // The count never passes the capacity
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (CAPACITY >= 32) || (32'(rsp_count) <= 32'(CAPACITY)))
      else $error("count beyond capacity");

endmodule

bind indexed_sequence_list_top isl_checker #(
   .CAPACITY (CAPACITY)
) u_isl_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_ok         (rsp_ch.ok),
   .rsp_read_value (rsp_ch.read_value),
   .rsp_count      (rsp_ch.count)
);

/* tb/tb_top.sv */
module tb_top;
   import isl_pkg::*;

   localparam int CAPACITY    = 16;
   localparam int OP_COUNT    = 600;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_WAIT  = 8;

   typedef struct {
      op_type                       opcode;
      logic [PositionWidth-1:0]     position;
      logic signed [ValueWidth-1:0] item_value;
   } list_op_type;

   typedef struct {
      logic                         ok;
      logic signed [ValueWidth-1:0] read_value;
      logic [CountWidth-1:0]        count;
   } list_outcome_type;

   logic clock;
   logic reset;

   isl_req_if req_ch ();
   isl_rsp_if rsp_ch ();

   indexed_sequence_list_top #(
      .CAPACITY (CAPACITY)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Pending request words and predicted response words
   list_op_type      op_queue[$];
   list_outcome_type outcome_q[$];

   // Shadow copy of the list, advanced on every accepted request word
   logic signed [ValueWidth-1:0] mirror_entries [CAPACITY];
   int                           mirror_fill;

   // Fill level as seen by the stimulus generator
   int gen_fill;

   int mismatches;
   int cycles;

   list_op_type on_wire;
   bit          req_fire;
   int          req_wait;
   int          req_level;
   int          rsp_stall;
   int          rsp_level;

   always #10 clock = ~clock;

   // Decide whether an operation takes effect on a list holding fill entries
   function automatic bit op_takes_effect(op_type opcode, logic [PositionWidth-1:0] pos,
                                          int fill);
      case (opcode)
         OP_APPEND, OP_PREPEND:       return fill < CAPACITY;
         OP_DROP_LAST, OP_DROP_FIRST: return fill > 0;
         OP_INSERT:                   return (fill < CAPACITY) && (int'(pos) <= fill);
         default:                     return int'(pos) < fill;
      endcase
   endfunction

   // Apply one operation to the shadow list and return the response it yields
   function automatic list_outcome_type apply_list_op(list_op_type op);
      list_outcome_type res;
      int               slot;
      int               i;
      res.ok         = op_takes_effect(op.opcode, op.position, mirror_fill);
      res.read_value = '0;
      if (res.ok) begin
         case (op.opcode)
            OP_APPEND, OP_PREPEND, OP_INSERT: begin
               if (op.opcode == OP_APPEND) slot = mirror_fill;
               else if (op.opcode == OP_PREPEND) slot = 0;
               else slot = int'(op.position);
               for (i = mirror_fill; i > slot; i--)
                  mirror_entries[i] = mirror_entries[i-1];
               mirror_entries[slot] = op.item_value;
               mirror_fill++;
            end
            OP_DROP_LAST, OP_DROP_FIRST, OP_REMOVE_AT: begin
               if (op.opcode == OP_DROP_LAST) slot = mirror_fill - 1;
               else if (op.opcode == OP_DROP_FIRST) slot = 0;
               else slot = int'(op.position);
               for (i = slot; i + 1 < mirror_fill; i++)
                  mirror_entries[i] = mirror_entries[i+1];
               mirror_fill--;
            end
            OP_READ: res.read_value = mirror_entries[int'(op.position)];
            default: mirror_entries[int'(op.position)] = op.item_value;
         endcase
      end
      res.count = CountWidth'(mirror_fill);
      return res;
   endfunction

   // Queue one request word and track the fill level it leads to
   function automatic void queue_op(op_type opcode, int pos, logic [31:0] value);
      list_op_type op;
      op.opcode     = opcode;
      op.position   = PositionWidth'(pos);
      op.item_value = value;
      op_queue.push_back(op);
      if (op_takes_effect(op.opcode, op.position, gen_fill)) begin
         case (opcode)
            OP_APPEND, OP_PREPEND, OP_INSERT:          gen_fill++;
            OP_DROP_LAST, OP_DROP_FIRST, OP_REMOVE_AT: gen_fill--;
            default: ;
         endcase
      end
   endfunction

   // Draw an idle count; level 0 never idles, level 1 idles now and then
   function automatic int draw_pause(int level);
      case (level)
         0:       return 0;
         1:       return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
         default: return $urandom_range(0, 17);
      endcase
   endfunction

   task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at cycle %0d: %s got 0x%08h expected 0x%08h", cycles, what, got, want);
      mismatches++;
   endtask

   // Driver: present queued words, predict each one as it is accepted
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_wait = draw_pause(req_level);
      end else begin
         req_fire = req_ch.valid && req_ch.ready;
         if (req_fire) begin
            outcome_q.push_back(apply_list_op(on_wire));
            if ($urandom_range(0, 31) == 0) req_level = $urandom_range(0, 2);
            req_wait = draw_pause(req_level);
         end
         if (!req_ch.valid || req_fire) begin
            if (req_wait > 0) begin
               req_wait--;
               req_ch.valid <= 1'b0;
            end else if (op_queue.size() != 0) begin
               on_wire = op_queue.pop_front();
               req_ch.valid      <= 1'b1;
               req_ch.opcode     <= on_wire.opcode;
               req_ch.position   <= on_wire.position;
               req_ch.item_value <= on_wire.item_value;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each accepted response word, then stall for a while
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (outcome_q.size() == 0) begin
               flag_mismatch("unexpected response ok", 32'(rsp_ch.ok), 32'd0);
            end else begin
               list_outcome_type want;
               want = outcome_q.pop_front();
               if (rsp_ch.ok !== want.ok)
                  flag_mismatch("ok", 32'(rsp_ch.ok), 32'(want.ok));
               if (rsp_ch.read_value !== want.read_value)
                  flag_mismatch("read_value", rsp_ch.read_value, want.read_value);
               if (rsp_ch.count !== want.count)
                  flag_mismatch("count", 32'(rsp_ch.count), 32'(want.count));
            end
            if ($urandom_range(0, 31) == 0) rsp_level = $urandom_range(0, 2);
            rsp_stall = draw_pause(rsp_level);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Abort a run that hangs
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("indexed_sequence_list_top regression: fail");
         $finish;
      end
   end

   initial begin
      int          phase_kind;
      int          phase_left;
      int          roll;
      int          pos;
      op_type      opcode;
      logic [31:0] value;

      clock             = 1'b0;
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.opcode     = OP_APPEND;
      req_ch.position   = '0;
      req_ch.item_value = '0;
      rsp_ch.ready      = 1'b0;
      mirror_fill       = 0;
      gen_fill          = 0;
      mismatches        = 0;
      cycles            = 0;
      req_level         = 1;
      rsp_level         = 1;
      phase_left        = 0;
      phase_kind        = 0;

      // Rejections on the empty list
      queue_op(OP_DROP_LAST, 0, 32'h0);
      queue_op(OP_DROP_FIRST, 0, 32'h0);
      queue_op(OP_READ, 0, 32'h0);
      queue_op(OP_WRITE, 0, 32'h1);
      queue_op(OP_REMOVE_AT, 0, 32'h0);
      queue_op(OP_INSERT, 1, 32'h2);
      // Build up from both ends and through insert at 0, in the middle and at the end
      queue_op(OP_INSERT, 0, 32'h8000_0000);
      queue_op(OP_APPEND, 0, 32'h7FFF_FFFF);
      queue_op(OP_PREPEND, 31, 32'h0);
      queue_op(OP_APPEND, 31, 32'hFFFF_FFFF);
      queue_op(OP_INSERT, 4, 32'h1234_5678);
      queue_op(OP_INSERT, 2, 32'h5555_5555);
      queue_op(OP_INSERT, 7, 32'h3);
      // Reads and writes in and out of range
      queue_op(OP_READ, 0, 32'hFFFF_FFFF);
      queue_op(OP_READ, 5, 32'h0);
      queue_op(OP_READ, 6, 32'h0);
      queue_op(OP_READ, 31, 32'h0);
      queue_op(OP_WRITE, 3, 32'hAAAA_AAAA);
      queue_op(OP_WRITE, 31, 32'h4);
      queue_op(OP_READ, 3, 32'h0);
      // Removals from the middle and both ends
      queue_op(OP_REMOVE_AT, 1, 32'h0);
      queue_op(OP_REMOVE_AT, 31, 32'h0);
      queue_op(OP_DROP_FIRST, 0, 32'h0);
      queue_op(OP_DROP_LAST, 0, 32'h0);
      queue_op(OP_READ, 0, 32'h0);

      // Random phases that grow, shrink or churn the list
      repeat (OP_COUNT) begin
         if (phase_left == 0) begin
            phase_kind = $urandom_range(0, 2);
            phase_left = $urandom_range(8, 40);
         end
         phase_left--;
         roll = $urandom_range(0, 99);
         case (phase_kind)
            0: roll = (roll < 70) ? 0 : (roll < 85) ? 1 : 2;
            1: roll = (roll < 70) ? 2 : (roll < 85) ? 1 : 0;
            default: roll = (roll < 35) ? 0 : (roll < 70) ? 1 : 2;
         endcase
         case (roll)
            0: begin
               case ($urandom_range(0, 2))
                  0:       opcode = OP_APPEND;
                  1:       opcode = OP_PREPEND;
                  default: opcode = OP_INSERT;
               endcase
            end
            1: opcode = ($urandom_range(0, 1) == 0) ? OP_READ : OP_WRITE;
            default: begin
               case ($urandom_range(0, 2))
                  0:       opcode = OP_DROP_LAST;
                  1:       opcode = OP_DROP_FIRST;
                  default: opcode = OP_REMOVE_AT;
               endcase
            end
         endcase
         // Mix in fully random words as noise
         if ($urandom_range(0, 19) == 0) opcode = op_type'($urandom_range(0, 7));
         if ($urandom_range(0, 9) == 0) pos = $urandom_range(0, 31);
         else pos = $urandom_range(0, gen_fill);
         case ($urandom_range(0, 9))
            0:       value = 32'h8000_0000;
            1:       value = 32'h7FFF_FFFF;
            2:       value = ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
            default: value = $urandom;
         endcase
         queue_op(opcode, pos, value);
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Wait for every word to go out and every response to come back
      while (op_queue.size() != 0 || req_ch.valid || outcome_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (mismatches == 0) begin
         $display("indexed_sequence_list_top regression: pass");
      end else begin
         $display("indexed_sequence_list_top regression: fail");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/isl_pkg.sv
rtl/core/isl_channels.sv
rtl/core/isl_controller.sv
rtl/core/isl_datapath.sv
rtl/core/indexed_sequence_list_top.sv
rtl/core/isl_checker.sv
tb/tb_top.sv
